FILE: src/otq_pkg.sv
// Shared types, constants and helpers of the one-shot timer queue.
// Used by otq_cell, one_shot_timer_queue_top, the checker and the testbench; depends on nothing.
package otq_pkg;

    // Sizes
    localparam int NUM_TIMERS = 16;
    localparam int TIME_WIDTH = 32;
    localparam int ID_WIDTH   = 16;
    localparam int DLY_WIDTH  = 16;
    localparam int MAX_OUT    = 16;
    localparam int IDX_W      = $clog2(NUM_TIMERS);
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int OUT_W      = $clog2(MAX_OUT + 1);

    // Request actions
    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOTFOUND  = 3'd3;
    localparam logic [2:0] KIND_EXPIRED   = 3'd4;

    // Slot commands
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [DLY_WIDTH-1:0] delay_ticks;
        logic [ID_WIDTH-1:0]  cancel_id;
    } req_t;

    typedef struct packed {
        logic [2:0]          result_kind;
        logic [ID_WIDTH-1:0] timer_id;
        logic                last;
    } rsp_t;

    // Candidate handed down the cell row
    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      idx;
        logic [TIME_WIDTH-1:0] expiry;
        logic [ID_WIDTH-1:0]   ident;
    } cand_t;

    // Search key broadcast to every cell
    typedef struct packed {
        logic [1:0]            mode;
        logic [ID_WIDTH-1:0]   cancel_id;
        logic [TIME_WIDTH-1:0] now;
    } bcast_t;

    // Slot update broadcast to every cell
    typedef struct packed {
        logic [1:0]            op;
        logic [IDX_W-1:0]      idx;
        logic [TIME_WIDTH-1:0] expiry;
        logic [ID_WIDTH-1:0]   ident;
    } cmd_t;

    // a is before b when (a - b) mod 2^TIME_WIDTH is negative
    function automatic logic time_before(input logic [TIME_WIDTH-1:0] a,
                                         input logic [TIME_WIDTH-1:0] b);
        logic [TIME_WIDTH-1:0] d;
        d = a - b;
        return d[TIME_WIDTH-1];
    endfunction

endpackage

FILE: src/otq_cell.sv
// One timer slot of the queue plus one stage of the candidate search row.
// Depends on otq_pkg.
module otq_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [otq_pkg::IDX_W-1:0] cell_idx,
    input  otq_pkg::bcast_t          key,
    input  otq_pkg::cmd_t            cmd,
    input  otq_pkg::cand_t           cand_in,
    output otq_pkg::cand_t           cand_out
);

    logic                              valid_reg;
    logic [otq_pkg::TIME_WIDTH-1:0]    expiry_reg;
    logic [otq_pkg::ID_WIDTH-1:0]      ident_reg;
    logic                              found_reg;
    logic [otq_pkg::IDX_W-1:0]         idx_reg;
    logic [otq_pkg::TIME_WIDTH-1:0]    cexp_reg;
    logic [otq_pkg::ID_WIDTH-1:0]      cid_reg;
    logic                              own_hit;
    logic                              better;
    logic                              take;
    logic                              sel;

    assign sel = (cmd.idx == cell_idx);

    // Slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sel && cmd.op == otq_pkg::CMD_WRITE)
        begin
            valid_reg <= 1'b1;
        end
        else if (sel && cmd.op == otq_pkg::CMD_CLEAR)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.op == otq_pkg::CMD_WRITE)
        begin
            expiry_reg <= cmd.expiry;
            ident_reg  <= cmd.ident;
        end
    end

    // Does this slot qualify for the current search
    always_comb
    begin
        case (key.mode)
            otq_pkg::ACT_ADD:    own_hit = !valid_reg;
            otq_pkg::ACT_CANCEL: own_hit = valid_reg && (ident_reg == key.cancel_id);
            otq_pkg::ACT_TICK:   own_hit = valid_reg &&
                                           !otq_pkg::time_before(key.now, expiry_reg);
            default:             own_hit = 1'b0;
        endcase
    end

    // In a tick, earlier expiry wins, then lower id; otherwise, and on a full tie, the lower slot is kept
    assign better = (key.mode == otq_pkg::ACT_TICK) &&
                    (otq_pkg::time_before(expiry_reg, cand_in.expiry) ||
                     (expiry_reg == cand_in.expiry && ident_reg < cand_in.ident));
    assign take   = own_hit && (!cand_in.found || better);

    // Candidate stage toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= take | cand_in.found;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_reg  <= cell_idx;
            cexp_reg <= expiry_reg;
            cid_reg  <= ident_reg;
        end
        else
        begin
            idx_reg  <= cand_in.idx;
            cexp_reg <= cand_in.expiry;
            cid_reg  <= cand_in.ident;
        end
    end

    assign cand_out = '{found: found_reg, idx: idx_reg, expiry: cexp_reg, ident: cid_reg};

    // A write only lands in a free slot
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (sel && cmd.op == otq_pkg::CMD_WRITE) |-> !valid_reg)
        else $error("write to a live slot");

    // A clear only hits a live slot
    a_clear_live: assert property (@(posedge clk) disable iff (!rst_n)
        (sel && cmd.op == otq_pkg::CMD_CLEAR) |-> valid_reg)
        else $error("clear of a free slot");

    // Found flag never drops along the row
    a_found_kept: assert property (@(posedge clk) disable iff (!rst_n)
        cand_in.found |=> found_reg)
        else $error("candidate lost in cell");

endmodule

FILE: src/one_shot_timer_queue_top.sv
// Top level of the one-shot timer queue: request control, time and id counters,
// and the row of otq_cell slots. Depends on otq_pkg and otq_cell.
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------
//  request   | start, busy            | req  (action, delay_ticks, cancel_id)
//  result    | result_valid (strobe)  | rsp  (result_kind, timer_id, last)
//
// Each search sends a candidate down the row of NUM_TIMERS cells, through the
// registered candidate stage of each cell in turn. Add and cancel take one
// search and issue one result.
// A tick runs one search per expired timer plus a final empty one when it finds
// fewer than MAX_OUT expirations; a full batch of MAX_OUT ends with a flush
// state instead of the empty search.
// busy is high from the cycle after acceptance until the last result is issued.
// Reset clears all slots' valid bits, the time and the id counter.
// Results are issued for one cycle each; the receiver cannot stall them.
module one_shot_timer_queue_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  otq_pkg::req_t req,
    output logic          result_valid,
    output otq_pkg::rsp_t rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]                     state_reg,    state_next;
    logic [otq_pkg::CNT_W-1:0]      cnt_reg,      cnt_next;
    logic [otq_pkg::OUT_W-1:0]      nout_reg,     nout_next;
    logic [1:0]                     action_reg,   action_next;
    logic [otq_pkg::DLY_WIDTH-1:0]  delay_reg,    delay_next;
    logic [otq_pkg::ID_WIDTH-1:0]   cid_reg,      cid_next;
    logic [otq_pkg::TIME_WIDTH-1:0] now_reg,      now_next;
    logic [otq_pkg::ID_WIDTH-1:0]   next_id_reg,  next_id_next;
    logic                           pend_reg,     pend_next;
    logic [otq_pkg::ID_WIDTH-1:0]   pend_id_reg,  pend_id_next;
    logic                           res_reg,      res_next;
    otq_pkg::rsp_t                  rsp_reg,      rsp_next;

    otq_pkg::cmd_t                  cmd;
    otq_pkg::bcast_t                key;
    otq_pkg::cand_t                 chain [otq_pkg::NUM_TIMERS+1];
    otq_pkg::cand_t                 best;
    logic                           scan_done;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_reg;
    assign rsp          = rsp_reg;

    // Cell row
    assign chain[0] = '0;
    assign key      = '{mode: action_reg, cancel_id: cid_reg, now: now_reg};
    assign best     = chain[otq_pkg::NUM_TIMERS];

    for (genvar i = 0; i < otq_pkg::NUM_TIMERS; i++)
    begin : g_cell
        otq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (otq_pkg::IDX_W'(i)),
            .key      (key),
            .cmd      (cmd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    assign scan_done = (state_reg == S_SCAN) &&
                       (cnt_reg == otq_pkg::CNT_W'(otq_pkg::NUM_TIMERS));

    // Control
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        nout_next    = nout_reg;
        action_next  = action_reg;
        delay_next   = delay_reg;
        cid_next     = cid_reg;
        now_next     = now_reg;
        next_id_next = next_id_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;
        res_next     = 1'b0;
        rsp_next     = rsp_reg;
        cmd          = '{op: otq_pkg::CMD_NONE, idx: best.idx, expiry: '0, ident: '0};

        case (state_reg)
            S_IDLE:
            begin
                if (start && (req.action == otq_pkg::ACT_ADD ||
                              req.action == otq_pkg::ACT_CANCEL ||
                              req.action == otq_pkg::ACT_TICK))
                begin
                    action_next = req.action;
                    delay_next  = req.delay_ticks;
                    cid_next    = req.cancel_id;
                    cnt_next    = '0;
                    nout_next   = '0;
                    pend_next   = 1'b0;
                    state_next  = S_SCAN;
                    if (req.action == otq_pkg::ACT_TICK)
                    begin
                        now_next = now_reg + 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (!scan_done)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    case (action_reg)
                        otq_pkg::ACT_ADD:
                        begin
                            res_next   = 1'b1;
                            state_next = S_IDLE;
                            if (best.found)
                            begin
                                cmd.op       = otq_pkg::CMD_WRITE;
                                cmd.expiry   = now_reg +
                                    otq_pkg::TIME_WIDTH'(delay_reg);
                                cmd.ident    = next_id_reg;
                                rsp_next     = '{result_kind: otq_pkg::KIND_ADDED,
                                                 timer_id: next_id_reg, last: 1'b1};
                                next_id_next = next_id_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next = '{result_kind: otq_pkg::KIND_FULL,
                                             timer_id: '0, last: 1'b1};
                            end
                        end
                        otq_pkg::ACT_CANCEL:
                        begin
                            res_next   = 1'b1;
                            state_next = S_IDLE;
                            if (best.found)
                            begin
                                cmd.op   = otq_pkg::CMD_CLEAR;
                                rsp_next = '{result_kind: otq_pkg::KIND_CANCELLED,
                                             timer_id: cid_reg, last: 1'b1};
                            end
                            else
                            begin
                                rsp_next = '{result_kind: otq_pkg::KIND_NOTFOUND,
                                             timer_id: cid_reg, last: 1'b1};
                            end
                        end
                        default:
                        begin
                            // Tick: hold one expiry back until we know if it is last
                            if (best.found)
                            begin
                                cmd.op       = otq_pkg::CMD_CLEAR;
                                res_next     = pend_reg;
                                rsp_next     = '{result_kind: otq_pkg::KIND_EXPIRED,
                                                 timer_id: pend_id_reg, last: 1'b0};
                                pend_next    = 1'b1;
                                pend_id_next = best.ident;
                                nout_next    = nout_reg + 1'b1;
                                cnt_next     = '0;
                                if (nout_next == otq_pkg::OUT_W'(otq_pkg::MAX_OUT))
                                begin
                                    state_next = S_FLUSH;
                                end
                            end
                            else
                            begin
                                res_next   = pend_reg;
                                rsp_next   = '{result_kind: otq_pkg::KIND_EXPIRED,
                                               timer_id: pend_id_reg, last: 1'b1};
                                pend_next  = 1'b0;
                                state_next = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_FLUSH:
            begin
                res_next   = 1'b1;
                rsp_next   = '{result_kind: otq_pkg::KIND_EXPIRED,
                               timer_id: pend_id_reg, last: 1'b1};
                pend_next  = 1'b0;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            nout_reg    <= '0;
            now_reg     <= '0;
            next_id_reg <= '0;
            pend_reg    <= 1'b0;
            res_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            nout_reg    <= nout_next;
            now_reg     <= now_next;
            next_id_reg <= next_id_next;
            pend_reg    <= pend_next;
            res_reg     <= res_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        delay_reg   <= delay_next;
        cid_reg     <= cid_next;
        pend_id_reg <= pend_id_next;
        rsp_reg     <= rsp_next;
    end

    // Results only come out of work that was in progress
    a_res_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a request in progress");

    // Scan counter never runs past the row length
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= otq_pkg::CNT_W'(otq_pkg::NUM_TIMERS)))
        else $error("scan counter overrun");

    // A tick never reports more than the allowed number of expirations
    a_nout_range: assert property (@(posedge clk) disable iff (!rst_n)
        nout_reg <= otq_pkg::OUT_W'(otq_pkg::MAX_OUT))
        else $error("too many expirations on one tick");

    // The last result of a request is followed by a gap
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && rsp.last) |=> !result_valid)
        else $error("result right after a last result");

endmodule

FILE: sim/one_shot_timer_queue_checker.sv
// Result checker for the one-shot timer queue: watches requests and results,
// keeps its own timer table and compares every result in order.
// Depends on otq_pkg.
module one_shot_timer_queue_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  otq_pkg::req_t req,
    input  logic          result_valid,
    input  otq_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending
);
    import otq_pkg::*;

    // Shadow timer table
    logic                  live [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] due_at [NUM_TIMERS];
    logic [ID_WIDTH-1:0]   owner_id [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] clock_now;
    logic [ID_WIDTH-1:0]   id_counter;

    rsp_t expected_rsp_q [$];
    int   errors;

    // a lies before b on the wrapping time line
    function automatic logic due_before(input logic [TIME_WIDTH-1:0] a,
                                        input logic [TIME_WIDTH-1:0] b);
        return $signed(a - b) < 0;
    endfunction

    // Apply one request to the table and queue the results it causes
    task automatic predict_request(input req_t r);
        rsp_t found_list [MAX_OUT];
        rsp_t item;
        int   n;
        int   slot;
        int   pick;
        int   i;
        int   k;
        bit   done;
        n = 0;
        slot = -1;
        case (r.action)
            ACT_ADD:
            begin
                for (i = 0; i < NUM_TIMERS; i++)
                    if (!live[i] && slot < 0)
                        slot = i;
                if (slot < 0)
                begin
                    found_list[0].result_kind = KIND_FULL;
                    found_list[0].timer_id = '0;
                end
                else
                begin
                    live[slot] = 1'b1;
                    due_at[slot] = clock_now + TIME_WIDTH'(r.delay_ticks);
                    owner_id[slot] = id_counter;
                    found_list[0].result_kind = KIND_ADDED;
                    found_list[0].timer_id = id_counter;
                    id_counter = id_counter + 1'b1;
                end
                n = 1;
            end
            ACT_CANCEL:
            begin
                // lowest slot wins when ids repeat after the counter wraps
                for (i = 0; i < NUM_TIMERS; i++)
                    if (live[i] && owner_id[i] == r.cancel_id && slot < 0)
                        slot = i;
                if (slot >= 0)
                begin
                    live[slot] = 1'b0;
                    found_list[0].result_kind = KIND_CANCELLED;
                end
                else
                    found_list[0].result_kind = KIND_NOTFOUND;
                found_list[0].timer_id = r.cancel_id;
                n = 1;
            end
            ACT_TICK:
            begin
                clock_now = clock_now + 1'b1;
                done = 1'b0;
                while (!done && n < MAX_OUT)
                begin
                    pick = -1;
                    for (i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (live[i] && !due_before(clock_now, due_at[i]))
                        begin
                            if (pick < 0 || due_before(due_at[i], due_at[pick]) ||
                                (due_at[i] == due_at[pick] &&
                                 owner_id[i] < owner_id[pick]))
                                pick = i;
                        end
                    end
                    if (pick < 0)
                        done = 1'b1;
                    else
                    begin
                        live[pick] = 1'b0;
                        found_list[n].result_kind = KIND_EXPIRED;
                        found_list[n].timer_id = owner_id[pick];
                        n++;
                    end
                end
            end
            default:
            begin
                // unused action: ignored
            end
        endcase
        for (k = 0; k < n; k++)
        begin
            item = found_list[k];
            item.last = (k == n - 1);
            expected_rsp_q.push_back(item);
        end
    endtask

    // Compare results first, then book the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                live[i] = 1'b0;
                due_at[i] = '0;
                owner_id[i] = '0;
            end
            clock_now = '0;
            id_counter = '0;
            expected_rsp_q.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: unexpected result kind %0d id %0d last %0d",
                                 $realtime, rsp.result_kind, rsp.timer_id, rsp.last);
                    errors++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.result_kind !== want.result_kind ||
                        rsp.timer_id !== want.timer_id || rsp.last !== want.last)
                    begin
                        if (errors < 10)
                        begin
                            $write("%0t: result mismatch: expected kind %0d id %0d last %0d",
                                   $realtime, want.result_kind, want.timer_id, want.last);
                            $display(", got kind %0d id %0d last %0d",
                                     rsp.result_kind, rsp.timer_id, rsp.last);
                        end
                        errors++;
                    end
                end
            end
            if (start && !busy)
                predict_request(req);
            pending <= expected_rsp_q.size();
            fail_count <= errors;
        end
    end

endmodule

FILE: sim/tb_one_shot_timer_queue_top.sv
// Testbench top of the one-shot timer queue: clock, reset, request stimulus
// and the verdict. Depends on otq_pkg, one_shot_timer_queue_top and the checker.
module tb_one_shot_timer_queue_top;
    import otq_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 2 * (MAX_OUT + 1) * (NUM_TIMERS + 1);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic result_valid;
    rsp_t rsp;
    int   fail_count;
    int   pending;

    int                  burst_left = 0;
    bit                  gaps_on = 1'b1;
    logic [ID_WIDTH-1:0] id_guess;

    always #1 clk = ~clk;

    one_shot_timer_queue_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .rsp          (rsp)
    );

    one_shot_timer_queue_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .rsp          (rsp),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Issue one request; returns at the edge that takes it
    task automatic send(input logic [1:0] act, input logic [DLY_WIDTH-1:0] dly,
                        input logic [ID_WIDTH-1:0] cid);
        req_t r;
        int   gap;
        r.action = act;
        r.delay_ticks = dly;
        r.cancel_id = cid;
        if (gaps_on && burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60)
                                              : $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        start <= 1'b1;
        req <= r;
        do @(posedge clk); while (busy);
        burst_left--;
    endtask

    // Hold requests until every expected result is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
    endtask

    // Run limit
    initial
    begin
        #40000000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [DLY_WIDTH-1:0] dly;
        logic [ID_WIDTH-1:0]  cid;
        int                   sel;
        int                   count;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tick, unused action, cancel of an unknown id
        send(ACT_TICK, 16'hFFFF, 16'h0000);
        send(ACT_UNUSED, 16'h1234, 16'hABCD);
        send(ACT_CANCEL, 16'h0000, 16'hFFFF);
        // fill all slots; odd slots fall due before even ones
        for (int i = 0; i < NUM_TIMERS; i++)
            send(ACT_ADD, (i % 2 == 0) ? 16'd1 : 16'd0, 16'(i));
        send(ACT_ADD, 16'd7, 16'h0000);
        send(ACT_CANCEL, 16'h00FF, 16'd5);
        send(ACT_ADD, 16'd0, 16'h5A5A);
        send(ACT_CANCEL, 16'h0000, 16'd5);
        // every slot falls due on this tick
        send(ACT_TICK, 16'h0000, 16'hFFFF);
        drain();

        // Random mix; cancels mostly aim at recently issued ids
        id_guess = 16'd17;
        count = 0;
        while (count < 175)
        begin
            sel = $urandom_range(0, 99);
            dly = 16'($urandom);
            cid = 16'($urandom);
            if (sel < 40)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 15)
                    dly = 16'($urandom_range(0, 12));
                else if (sel < 18)
                    dly = 16'($urandom_range(13, 400));
                send(ACT_ADD, dly, cid);
                id_guess = id_guess + 1'b1;
                count++;
            end
            else if (sel < 65)
            begin
                if ($urandom_range(0, 4) != 0)
                    cid = id_guess - 16'($urandom_range(1, 24));
                send(ACT_CANCEL, dly, cid);
                count++;
            end
            else if (sel < 97)
            begin
                send(ACT_TICK, dly, cid);
                count++;
            end
            else
                send(ACT_UNUSED, dly, cid);
            if ($urandom_range(0, 59) == 0)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
